### hw/rtl/bses_pkg.sv
// ----------------------------------------------------------------------------
// bses_pkg
// shared types and constants for the bubble sort core with early exit
// ----------------------------------------------------------------------------
package bses_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int DATA_W    = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflow;
  } out_t;

  // result of the shared compare unit
  typedef struct packed {
    logic                     swap;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
  } cmp_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_START,
    ST_SORT_PRIME,
    ST_SORT_RUN,
    ST_SORT_TAIL,
    ST_EMIT_ADDR,
    ST_EMIT_FILL
  } state_t;

endpackage

### hw/rtl/bses_ram.sv
// ----------------------------------------------------------------------------
// bses_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bses_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/bses_cmp.sv
// ----------------------------------------------------------------------------
// bses_cmp
// signed compare and order unit shared by every step of a pass
// ----------------------------------------------------------------------------
module bses_cmp (
  input  logic signed [bses_pkg::DATA_W-1:0] left,
  input  logic signed [bses_pkg::DATA_W-1:0] right,
  output bses_pkg::cmp_t                     res
);

  // strict greater keeps equal values in arrival order
  always_comb begin
    res.swap = left > right;
    res.lo   = res.swap ? right : left;
    res.hi   = res.swap ? left : right;
  end

endmodule

### hw/rtl/bubble_sort_early_exit_core.sv
// ----------------------------------------------------------------------------
// bubble_sort_early_exit_core
// collects a set of signed words, bubble sorts it in place, streams it out
// ----------------------------------------------------------------------------
// loading: after a transaction without last the core is ready again the next cycle
// sorting (n stored words, n >= 2): at most n passes, each a prime, a run
//   of compares and a tail; one compare per cycle in the run through the
//   shared compare unit and the single read / single write port of the store
// emitting: results are read one at a time through the store read port and wait out stalls
// reset: synchronous, active low; clears control, the store is not cleared
// ----------------------------------------------------------------------------
module bubble_sort_early_exit_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  bses_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output bses_pkg::out_t  out_data
);

  // control registers
  bses_pkg::state_t             state_r, state_nxt;
  logic [bses_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [bses_pkg::ADDR_W-1:0]  pos_r, pos_nxt;
  logic [bses_pkg::ADDR_W-1:0]  idx_r, idx_nxt;
  logic                         swap_r, swap_nxt;
  logic                         dropped_r, dropped_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // payload registers
  logic signed [bses_pkg::DATA_W-1:0] carry_r, carry_nxt;
  bses_pkg::out_t                     out_data_r, out_data_nxt;

  // store port and compare unit
  logic                               wr_en;
  logic [bses_pkg::ADDR_W-1:0]        wr_addr;
  logic [bses_pkg::DATA_W-1:0]        wr_data;
  logic [bses_pkg::ADDR_W-1:0]        rd_addr;
  logic [bses_pkg::DATA_W-1:0]        rd_data;
  bses_pkg::cmp_t                     cmp_res;

  // handshake helpers
  logic                         in_take;
  logic                         has_room;
  logic [bses_pkg::CNT_W-1:0]   count_inc;
  logic                         last_pair;
  logic                         out_free;
  logic                         last_emit;

  bses_ram #(
    .DEPTH (bses_pkg::MAX_ITEMS),
    .WIDTH (bses_pkg::DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // carry holds the running maximum of the pass, the store word is its neighbor
  bses_cmp u_cmp (
    .left  (carry_r),
    .right (rd_data),
    .res   (cmp_res)
  );

  assign in_stall  = (state_r != bses_pkg::ST_LOAD);
  assign in_take   = in_valid && !in_stall;
  assign has_room  = (count_r < bses_pkg::CNT_W'(bses_pkg::MAX_ITEMS));
  assign count_inc = count_r + bses_pkg::CNT_W'(has_room);
  // pos and pos+1 are the final pair of the pass
  assign last_pair = (({1'b0, pos_r} + bses_pkg::CNT_W'(2)) == count_r);
  // output register empty, or its transaction completes this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign last_emit = (({1'b0, idx_r} + bses_pkg::CNT_W'(1)) == count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bses_pkg::ST_LOAD: begin
        if (in_take && in_data.last) begin
          // a single stored word needs no sorting
          state_nxt = (count_inc >= bses_pkg::CNT_W'(2)) ? bses_pkg::ST_SORT_START
                                                        : bses_pkg::ST_EMIT_ADDR;
        end
      end
      bses_pkg::ST_SORT_START: state_nxt = bses_pkg::ST_SORT_PRIME;
      bses_pkg::ST_SORT_PRIME: state_nxt = bses_pkg::ST_SORT_RUN;
      bses_pkg::ST_SORT_RUN: begin
        if (last_pair) begin
          state_nxt = bses_pkg::ST_SORT_TAIL;
        end
      end
      bses_pkg::ST_SORT_TAIL: begin
        // early exit: a pass without a swap leaves the set in order
        state_nxt = swap_r ? bses_pkg::ST_SORT_PRIME : bses_pkg::ST_EMIT_ADDR;
      end
      bses_pkg::ST_EMIT_ADDR: state_nxt = bses_pkg::ST_EMIT_FILL;
      bses_pkg::ST_EMIT_FILL: begin
        if (out_free) begin
          state_nxt = last_emit ? bses_pkg::ST_LOAD : bses_pkg::ST_EMIT_ADDR;
        end
      end
      default: state_nxt = bses_pkg::ST_LOAD;
    endcase
  end

  // datapath control and register next values
  always_comb begin
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    swap_nxt      = swap_r;
    dropped_nxt   = dropped_r;
    carry_nxt     = carry_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = count_r[bses_pkg::ADDR_W-1:0];
    wr_data       = in_data.value;
    rd_addr       = '0;

    case (state_r)
      bses_pkg::ST_LOAD: begin
        if (in_take) begin
          if (has_room) begin
            wr_en     = 1'b1;
            count_nxt = count_inc;
          end else begin
            // store full: word dropped, set still ends on last
            dropped_nxt = 1'b1;
          end
        end
      end
      bses_pkg::ST_SORT_START: begin
        rd_addr = '0;
      end
      bses_pkg::ST_SORT_PRIME: begin
        // word 0 arrives and becomes the carry, fetch word 1
        carry_nxt = rd_data;
        rd_addr   = bses_pkg::ADDR_W'(1);
        pos_nxt   = '0;
        swap_nxt  = 1'b0;
      end
      bses_pkg::ST_SORT_RUN: begin
        // smaller word settles at pos, larger one travels on
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = cmp_res.lo;
        carry_nxt = cmp_res.hi;
        swap_nxt  = swap_r || cmp_res.swap;
        rd_addr   = bses_pkg::ADDR_W'(pos_r + bses_pkg::ADDR_W'(2));
        pos_nxt   = pos_r + bses_pkg::ADDR_W'(1);
      end
      bses_pkg::ST_SORT_TAIL: begin
        // pass maximum lands in the top slot, refetch word 0 for the next pass
        wr_en   = 1'b1;
        wr_addr = bses_pkg::ADDR_W'(count_r - bses_pkg::CNT_W'(1));
        wr_data = carry_r;
        rd_addr = '0;
        idx_nxt = '0;
      end
      bses_pkg::ST_EMIT_ADDR: begin
        rd_addr = idx_r;
      end
      bses_pkg::ST_EMIT_FILL: begin
        rd_addr = idx_r;
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.sorted_value = rd_data;
          out_data_nxt.final_res    = last_emit;
          out_data_nxt.overflow     = dropped_r;
          if (last_emit) begin
            // set done, empty store for the next one
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            idx_nxt     = '0;
            pos_nxt     = '0;
            swap_nxt    = 1'b0;
          end else begin
            idx_nxt = idx_r + bses_pkg::ADDR_W'(1);
          end
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bses_pkg::ST_LOAD;
      count_r     <= '0;
      pos_r       <= '0;
      idx_r       <= '0;
      swap_r      <= 1'b0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      idx_r       <= idx_nxt;
      swap_r      <= swap_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r    <= carry_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/bses_checker.sv
// ----------------------------------------------------------------------------
// bses_port_checker
// port level checks for the bubble sort core, bound to the top level
// ----------------------------------------------------------------------------
module bses_port_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input bses_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input bses_pkg::out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a transaction without last keeps the block loading
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.last |=> !in_stall)
    else $error("block stopped loading mid set");

  // a transaction with last starts the sort or emit sequence
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("block still loading after end of set");

  // while loading, only the final result of a set can still be pending
  a_pending_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !in_stall |-> out_data.final_res)
    else $error("non-final result pending while loading");

endmodule

bind bubble_sort_early_exit_core bses_port_checker u_bses_port_checker (.*);
